// ===== src/pfb_pkg.sv =====
// Package for the page framebuffer blitter: request/response payload types,
// status and mode codes, and the command word passed from front to back.
// No dependencies.
package pfb_pkg;

  // Default frame size in pixels
  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 64;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Request modes
  localparam logic [2:0] MODE_OPEN  = 3'd0;
  localparam logic [2:0] MODE_BYTE  = 3'd1;
  localparam logic [2:0] MODE_FILL  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_ORPHAN  = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] rect_w;
    logic [6:0] rect_h;
    logic       invert;
    logic [7:0] data_byte;
    logic [9:0] read_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       blit_done;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BLIT,
    OP_FILL,
    OP_CLEAR,
    OP_READ
  } cmd_op_t;

  // One unit of back-end work. Blit: x0 = column, xend = column + 1,
  // y0 = first row, mask = rows to write, data = pixel values.
  // Fill: columns [x0, xend), rows [y0, yend), data = all set or all clear.
  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] status;
    logic       done;
    logic [8:0] x0;
    logic [8:0] xend;
    logic [7:0] y0;
    logic [7:0] yend;
    logic [7:0] mask;
    logic [7:0] data;
    logic [9:0] read_index;
  } cmd_t;

endpackage

// ===== src/pfb_front.sv =====
// Front end of the blitter: accepts requests, tracks the open blit and its
// cursors, and turns each request into one command word. Uses pfb_pkg.
module pfb_front import pfb_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  input  logic init_busy,
  input  logic q_ready,
  output logic push,
  output cmd_t cmd
);

  // Blit state
  logic [6:0] origin_x;
  logic [5:0] origin_y;
  logic [7:0] blit_width;
  logic [6:0] blit_height;
  logic       blit_invert;
  logic [7:0] column_cursor;
  logic [3:0] band_cursor;
  logic       blit_open;

  logic [7:0] open_w;
  logic [6:0] open_h;
  logic [8:0] blit_col;
  logic [7:0] blit_row0;
  logic [7:0] band_row;
  logic [7:0] in_blit;
  logic [7:0] row_ok;
  logic       blit_clipped;
  logic [7:0] col_next;
  logic       band_end;
  logic       last_band;
  logic [8:0] fill_xsum;
  logic [7:0] fill_ysum;
  logic       fill_clipped;

  assign req_ready = q_ready && !init_busy;
  assign push      = req_valid && req_ready;

  // Saturate the blit size to the frame
  always_comb begin
    open_w = (32'(req.rect_w) > FRAME_WIDTH)  ? 8'(FRAME_WIDTH)  : req.rect_w;
    open_h = (32'(req.rect_h) > FRAME_HEIGHT) ? 7'(FRAME_HEIGHT) : req.rect_h;
  end

  // Locate the current source byte and find which of its rows land in frame
  always_comb begin
    blit_col  = 9'(origin_x) + 9'(column_cursor);
    blit_row0 = 8'(origin_y) + {1'b0, band_cursor, 3'b000};
    band_row  = 8'd0;
    for (int k = 0; k < 8; k++) begin
      band_row   = {1'b0, band_cursor, 3'b000} + 8'(k);
      in_blit[k] = band_row < {1'b0, blit_height};
      row_ok[k]  = in_blit[k] && (32'(blit_col) < FRAME_WIDTH)
                   && ((int'(blit_row0) + k) < FRAME_HEIGHT);
    end
    blit_clipped = |(in_blit & ~row_ok);
    col_next     = column_cursor + 8'd1;
    band_end     = col_next >= blit_width;
    last_band    = ({1'b0, band_cursor, 3'b000} + 8'd8) >= {1'b0, blit_height};
  end

  // Clip the fill rectangle against the frame
  always_comb begin
    fill_xsum    = 9'(req.pos_x) + 9'(req.rect_w);
    fill_ysum    = 8'(req.pos_y) + 8'(req.rect_h);
    fill_clipped = (req.rect_w != 8'd0) && (req.rect_h != 7'd0)
                   && ((32'(fill_xsum) > FRAME_WIDTH) || (32'(fill_ysum) > FRAME_HEIGHT));
  end

  // Build the command word
  always_comb begin
    cmd            = '0;
    cmd.op         = OP_NOP;
    cmd.status     = ST_OK;
    cmd.read_index = req.read_index;
    case (req.mode)
      MODE_BYTE: begin
        if (!blit_open) begin
          cmd.status = ST_ORPHAN;
        end else begin
          cmd.op     = OP_BLIT;
          cmd.status = blit_clipped ? ST_CLIPPED : ST_OK;
          cmd.done   = band_end && last_band;
          cmd.x0     = blit_col;
          cmd.xend   = blit_col + 9'd1;
          cmd.y0     = blit_row0;
          cmd.mask   = row_ok;
          cmd.data   = req.data_byte ^ {8{blit_invert}};
        end
      end
      MODE_FILL: begin
        cmd.op     = OP_FILL;
        cmd.status = fill_clipped ? ST_CLIPPED : ST_OK;
        cmd.x0     = 9'(req.pos_x);
        cmd.xend   = (32'(fill_xsum) > FRAME_WIDTH) ? 9'(FRAME_WIDTH) : fill_xsum;
        cmd.y0     = 8'(req.pos_y);
        cmd.yend   = (32'(fill_ysum) > FRAME_HEIGHT) ? 8'(FRAME_HEIGHT) : fill_ysum;
        cmd.data   = {8{req.invert}};
      end
      MODE_CLEAR: cmd.op = OP_CLEAR;
      MODE_READ:  cmd.op = OP_READ;
      default:    cmd.op = OP_NOP;
    endcase
  end

  // Update blit state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      blit_width    <= '0;
      blit_height   <= '0;
      blit_invert   <= 1'b0;
      column_cursor <= '0;
      band_cursor   <= '0;
      blit_open     <= 1'b0;
    end else if (push) begin
      if (req.mode == MODE_OPEN) begin
        origin_x      <= req.pos_x;
        origin_y      <= req.pos_y;
        blit_width    <= open_w;
        blit_height   <= open_h;
        blit_invert   <= req.invert;
        column_cursor <= '0;
        band_cursor   <= '0;
        blit_open     <= (open_w != 8'd0) && (open_h != 7'd0);
      end else if (req.mode == MODE_BYTE && blit_open) begin
        if (!band_end) begin
          column_cursor <= col_next;
        end else begin
          column_cursor <= '0;
          if (last_band) begin
            band_cursor <= '0;
            blit_open   <= 1'b0;
          end else begin
            band_cursor <= band_cursor + 4'd1;
          end
        end
      end
    end
  end

endmodule

// ===== src/pfb_queue.sv =====
// Short command queue between the blitter front end and back end.
// Uses pfb_pkg for the command word and depth.
module pfb_queue import pfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign push_ready = count < QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];

  // Store commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/pfb_back.sv =====
// Back end of the blitter: owns the frame memory, executes commands by
// read-modify-write walks and sweeps, and holds the response register. Uses pfb_pkg.
module pfb_back import pfb_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic init_busy,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int FramePages = (FRAME_HEIGHT + 7) / 8;
  localparam int FrameBytes = FRAME_WIDTH * FramePages;
  localparam int AddrW      = $clog2(FrameBytes);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_WR,
    S_READ,
    S_FINISH
  } state_t;

  logic [7:0]       mem [FrameBytes];
  state_t           state;
  cmd_t             cmd;
  logic [8:0]       cur_col;
  logic [4:0]       cur_page;
  logic [4:0]       last_page;
  logic [AddrW-1:0] clr_addr;
  logic [7:0]       rd_q;

  logic [AddrW-1:0] walk_addr;
  logic [AddrW-1:0] mem_addr;
  logic [15:0]      blit_mask16;
  logic [15:0]      blit_data16;
  logic             hi_sel;
  logic [7:0]       fill_mask;
  logic [7:0]       page_row;
  logic [7:0]       byte_mask;
  logic [7:0]       byte_data;
  logic             clearing;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             read_in_range;
  logic             clr_last;
  logic             col_more;
  logic [7:0]       yend_m1;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = (state == S_INIT);
  assign clearing  = (state == S_INIT) || (state == S_CLEAR);
  assign clr_last  = clr_addr == AddrW'(FrameBytes - 1);
  assign col_more  = (cur_col + 9'd1) < cmd.xend;
  assign yend_m1   = q_cmd.yend - 8'd1;
  assign read_in_range = 32'(cmd.read_index) < FrameBytes;

  // Pick the memory address for this cycle
  always_comb begin
    walk_addr = AddrW'(int'(cur_col) + int'(cur_page) * FRAME_WIDTH);
    if (clearing) begin
      mem_addr = clr_addr;
    end else if (cmd.op == OP_READ) begin
      mem_addr = AddrW'(cmd.read_index);
    end else begin
      mem_addr = walk_addr;
    end
  end

  // Form the bit mask and pixel values for the byte under the walker
  always_comb begin
    blit_mask16 = {8'd0, cmd.mask} << cmd.y0[2:0];
    blit_data16 = {8'd0, cmd.data} << cmd.y0[2:0];
    hi_sel      = cur_page != cmd.y0[7:3];
    page_row    = 8'd0;
    for (int k = 0; k < 8; k++) begin
      page_row     = {cur_page, 3'(k)};
      fill_mask[k] = (page_row >= cmd.y0) && (page_row < cmd.yend);
    end
    if (cmd.op == OP_BLIT) begin
      byte_mask = hi_sel ? blit_mask16[15:8] : blit_mask16[7:0];
      byte_data = hi_sel ? blit_data16[15:8] : blit_data16[7:0];
    end else begin
      byte_mask = fill_mask;
      byte_data = cmd.data;
    end
    wr_en   = clearing || ((state == S_WR) && (byte_mask != 8'd0));
    wr_data = clearing ? 8'h00 : ((rd_q & ~byte_mask) | (byte_data & byte_mask));
  end

  // Frame memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= wr_data;
    end
    rd_q <= mem[mem_addr];
  end

  // Sequence commands and hold the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          clr_addr <= clr_addr + AddrW'(1);
          if (clr_last) begin
            state <= (state == S_INIT) ? S_IDLE : S_FINISH;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd      <= q_cmd;
            cur_col  <= q_cmd.x0;
            cur_page <= q_cmd.y0[7:3];
            clr_addr <= '0;
            case (q_cmd.op)
              OP_BLIT: begin
                last_page <= q_cmd.y0[7:3] + 5'd1;
                state     <= S_RD;
              end
              OP_FILL: begin
                last_page <= yend_m1[7:3];
                if (q_cmd.x0 < q_cmd.xend && q_cmd.y0 < q_cmd.yend) begin
                  state <= S_RD;
                end else begin
                  state <= S_FINISH;
                end
              end
              OP_CLEAR: state <= S_CLEAR;
              OP_READ:  state <= S_READ;
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (col_more) begin
            cur_col <= cur_col + 9'd1;
            state   <= S_RD;
          end else if (cur_page == last_page) begin
            state <= S_FINISH;
          end else begin
            cur_col  <= cmd.x0;
            cur_page <= cur_page + 5'd1;
            state    <= S_RD;
          end
        end
        S_READ: state <= S_FINISH;
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            rsp.read_data <= (cmd.op == OP_READ && read_in_range) ? rd_q : 8'h00;
            rsp.status    <= cmd.status;
            rsp.blit_done <= cmd.done;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/page_framebuffer_blitter.sv =====
// Top level of the page framebuffer blitter: front end, command queue and
// back end with the frame memory. Uses pfb_pkg, pfb_front, pfb_queue, pfb_back.
//
// A 1-bit frame of FRAME_WIDTH x FRAME_HEIGHT pixels held page-packed: byte
// address = column + page * FRAME_WIDTH, bit (row % 8) is the pixel.
// Requests arrive on req (valid/ready); each produces exactly one response on
// rsp (valid/ready), in order. Modes: open a blit, source byte, fill
// rectangle, clear all, read byte; unused modes answer all zero.
// The front end updates blit cursors as it accepts a request and queues a
// command; the back end works one command at a time on the single-port memory.
// From leaving the queue to the response register, a source byte is a
// read-modify-write of two frame bytes, a fill is one read-modify-write per
// frame byte touched, a clear sweeps every frame byte, and a read is one
// registered memory read; open blit, orphan byte and unused modes only answer.
// After reset the back end sweeps the frame to zero, one byte a cycle, over all
// FRAME_WIDTH * ceil(FRAME_HEIGHT / 8) bytes; req_ready stays low meanwhile.
// While the receiver stalls, the response register holds its result and the
// queue keeps taking up to two more requests before req_ready drops.
module page_framebuffer_blitter import pfb_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic init_busy;
  logic q_ready;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  pfb_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .init_busy(init_busy),
    .q_ready  (q_ready),
    .push     (push),
    .cmd      (push_cmd)
  );

  pfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(q_ready),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  pfb_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .init_busy(init_busy),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Start the clearing sweep right after reset
  a_init_after_reset: assert property (@(posedge clk) $past(rst) && !rst |-> init_busy)
    else $error("clearing sweep not running after reset");

  // Hold off requests during the clearing sweep
  a_no_req_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !req_ready)
    else $error("request accepted during clearing sweep");

  // Drop blit_done on an orphan byte
  a_orphan_not_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_ORPHAN |-> !rsp.blit_done)
    else $error("orphan byte reported as last of blit");

  // Only a read answers with data, and a read is never clipped or done
  a_read_data_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_data != 8'h00 |-> rsp.status == ST_OK && !rsp.blit_done)
    else $error("read data on a non-read response");

endmodule
